// ----- rtl/gcp_pkg.sv -----
`default_nettype none

package gcp_pkg;

    // fraction bits of the rotation coefficients
    localparam int ROT_FRAC = 14;

    // quotient bits of the pipelined dividers (results saturate at 2^31-1)
    localparam int QUO_BITS = 31;

    typedef enum logic [2:0] {
        CFG_ROT_ROW0 = 3'd0,
        CFG_ROT_ROW1 = 3'd1,
        CFG_ROT_ROW2 = 3'd2,
        CFG_FOCAL_X  = 3'd3,
        CFG_FOCAL_Y  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONPOS = 2'd1,
        ST_SAT    = 2'd2
    } status_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat32_t;

    typedef struct packed {
        logic               ovf;
        logic signed [47:0] val;
    } sat48_t;

    function automatic sat32_t sat32(input logic signed [63:0] v);
        sat32_t r;
        r.ovf = 1'b0;
        r.val = v[31:0];
        if (v > 64'sd2147483647)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    function automatic sat48_t sat48(input logic signed [63:0] v);
        sat48_t r;
        r.ovf = 1'b0;
        r.val = v[47:0];
        if (v > 64'sh0000_7fff_ffff_ffff)
        begin
            r.ovf = 1'b1;
            r.val = 48'sh7fff_ffff_ffff;
        end
        else if (v < -64'sh0000_8000_0000_0000)
        begin
            r.ovf = 1'b1;
            r.val = 48'sh8000_0000_0000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gaussian_covariance_projection.sv -----
`default_nettype none

// channel   | handshake                        | payload
// ----------+----------------------------------+--------------------------------------
// item      | item_valid / item_ready          | cov_xx..cov_zz, cam_x, cam_y, cam_z
// result    | result_valid / result_ready      | screen_cov_xx/xy/yy, status
// config    | cfg_we (no wait, no read-back)   | cfg_index, cfg_data
//
// one word per cycle in steady state while the result side does not stall; pipeline stages
// (5 for camera covariance, 33 per divider, 1 for a*|x|, 4 for J*C*J^T)
// the whole pipeline advances together; a stall comes only from the result side
// and holds every stage, so nothing is lost or repeated
// reset clears valid bits and loads identity rotation and unit focal lengths
module gaussian_covariance_projection
    import gcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data,

    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic signed [31:0] cov_xx,
    input  wire logic signed [31:0] cov_xy,
    input  wire logic signed [31:0] cov_xz,
    input  wire logic signed [31:0] cov_yy,
    input  wire logic signed [31:0] cov_yz,
    input  wire logic signed [31:0] cov_zz,
    input  wire logic signed [31:0] cam_x,
    input  wire logic signed [31:0] cam_y,
    input  wire logic signed [31:0] cam_z,

    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [47:0]      screen_cov_xx,
    output logic signed [47:0]      screen_cov_xy,
    output logic signed [47:0]      screen_cov_yy,
    output logic [1:0]              status
);

    localparam int QB      = QUO_BITS;
    localparam int NUM1_W  = 32 + FRAC_BITS;
    localparam int NUM2_W  = 2 * QB;
    localparam int SIDE1_W = 6 * 32 + 32 + 32 + QB + 2;
    localparam int SIDE2_W = 6 * 32 + 2 * QB + 4;
    localparam logic signed [49:0] HALF_R50 = 50'sd1 <<< (ROT_FRAC - 1);
    localparam logic signed [53:0] HALF_R54 = 54'sd1 <<< (ROT_FRAC - 1);
    localparam logic signed [64:0] HALF_F   = 65'sd1 <<< (FRAC_BITS - 1);
    // upper-triangle order of the camera covariance: 00 01 02 11 12 22
    localparam int CI [0:5] = '{0, 0, 0, 1, 1, 2};
    localparam int CJ [0:5] = '{0, 1, 2, 1, 2, 2};

    // configuration
    logic [47:0] rot_reg [0:2];
    logic [31:0] fx_reg, fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= 48'h0000_0000_4000;
            rot_reg[1] <= 48'h0000_4000_0000;
            rot_reg[2] <= 48'h4000_0000_0000;
            fx_reg     <= 32'd1 << FRAC_BITS;
            fy_reg     <= 32'd1 << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROT_ROW0: rot_reg[0] <= cfg_data;
                CFG_ROT_ROW1: rot_reg[1] <= cfg_data;
                CFG_ROT_ROW2: rot_reg[2] <= cfg_data;
                CFG_FOCAL_X:  fx_reg     <= cfg_data[31:0];
                CFG_FOCAL_Y:  fy_reg     <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    logic signed [15:0] r_m [0:2][0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r_m[i][k] = rot_reg[i][16*k +: 16];
            end
        end
    end

    // global advance: every stage moves when the output register can move
    logic adv, result_valid_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    // valid bits of stages a..e, f, g..i
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg, vh_reg, vi_reg;
    logic d1_valid, d2_valid;

    // centre carried alongside stages a..e
    logic signed [31:0] xp_reg [0:4];
    logic signed [31:0] yp_reg [0:4];
    logic signed [31:0] zp_reg [0:4];

    // stage a: input capture
    logic signed [31:0] s_reg [0:5];
    logic signed [31:0] s_m [0:2][0:2];

    always_comb
    begin
        s_m[0][0] = s_reg[0];
        s_m[0][1] = s_reg[1];
        s_m[1][0] = s_reg[1];
        s_m[0][2] = s_reg[2];
        s_m[2][0] = s_reg[2];
        s_m[1][1] = s_reg[3];
        s_m[1][2] = s_reg[4];
        s_m[2][1] = s_reg[4];
        s_m[2][2] = s_reg[5];
    end

    // stage b: R*S partial products
    logic signed [47:0] pt_reg [0:2][0:2][0:2];
    // stage c: T = R*S rounded
    logic signed [35:0] t_reg [0:2][0:2];
    logic signed [49:0] t_sum [0:2][0:2];
    // stage d: T*R^T partial products
    logic signed [51:0] pc_reg [0:5][0:2];
    // stage e: camera covariance, saturated
    logic signed [31:0] c_reg [0:5];
    logic               fe_reg;
    logic signed [53:0] c_sum [0:5];
    sat32_t             c_sat [0:5];
    logic               c_ovf;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t_sum[i][j] = (50'(pt_reg[i][j][0]) + 50'(pt_reg[i][j][1])
                               + 50'(pt_reg[i][j][2]) + HALF_R50) >>> ROT_FRAC;
            end
        end
        c_ovf = 1'b0;
        for (int e = 0; e < 6; e++)
        begin
            c_sum[e] = (54'(pc_reg[e][0]) + 54'(pc_reg[e][1]) + 54'(pc_reg[e][2])
                        + HALF_R54) >>> ROT_FRAC;
            c_sat[e] = sat32(64'(c_sum[e]));
            c_ovf    = c_ovf | c_sat[e].ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0]  <= cov_xx;
            s_reg[1]  <= cov_xy;
            s_reg[2]  <= cov_xz;
            s_reg[3]  <= cov_yy;
            s_reg[4]  <= cov_yz;
            s_reg[5]  <= cov_zz;
            xp_reg[0] <= cam_x;
            yp_reg[0] <= cam_y;
            zp_reg[0] <= cam_z;
            for (int n = 1; n < 5; n++)
            begin
                xp_reg[n] <= xp_reg[n-1];
                yp_reg[n] <= yp_reg[n-1];
                zp_reg[n] <= zp_reg[n-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pt_reg[i][j][k] <= 48'(r_m[i][k]) * 48'(s_m[k][j]);
                    end
                    t_reg[i][j] <= t_sum[i][j][35:0];
                end
            end
            for (int e = 0; e < 6; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pc_reg[e][k] <= 52'(t_reg[CI[e]][k]) * 52'(r_m[CJ[e]][k]);
                end
                c_reg[e] <= c_sat[e].val;
            end
            fe_reg <= c_ovf;
        end
    end

    // first divider: a = fx/z, c = fy/z
    logic [SIDE1_W-1:0] d1_side_in, d1_side;
    logic [QB-1:0]      d1_a, d1_c;
    logic               d1_sa, d1_sc;
    logic signed [31:0] d1_cv [0:5];
    logic signed [31:0] d1_x, d1_y;
    logic [QB-1:0]      d1_z;
    logic               d1_np, d1_fl, nonpos_e;

    assign nonpos_e   = zp_reg[4] <= 32'sd0;
    assign d1_side_in = {c_reg[0], c_reg[1], c_reg[2], c_reg[3], c_reg[4], c_reg[5],
                         xp_reg[4], yp_reg[4], zp_reg[4][QB-1:0], nonpos_e, fe_reg};
    assign {d1_cv[0], d1_cv[1], d1_cv[2], d1_cv[3], d1_cv[4], d1_cv[5],
            d1_x, d1_y, d1_z, d1_np, d1_fl} = d1_side;

    gcp_div_pipe #(
        .NUM_W  (NUM1_W),
        .SIDE_W (SIDE1_W)
    ) u_div_focal (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ve_reg),
        .num0      ({fx_reg, {FRAC_BITS{1'b0}}}),
        .num1      ({fy_reg, {FRAC_BITS{1'b0}}}),
        .den       (zp_reg[4][QB-1:0]),
        .side      (d1_side_in),
        .out_valid (d1_valid),
        .quo0      (d1_a),
        .quo1      (d1_c),
        .sat0      (d1_sa),
        .sat1      (d1_sc),
        .side_out  (d1_side)
    );

    // stage f: magnitudes a*|x| and c*|y|
    logic [31:0]        abs_x, abs_y;
    logic [NUM2_W-1:0]  prodx_reg, prody_reg;
    logic [QB-1:0]      af_reg, cf_reg, zf_reg;
    logic signed [31:0] cvf_reg [0:5];
    logic               xneg_f_reg, yneg_f_reg, npf_reg, flf_reg;

    assign abs_x = d1_x[31] ? unsigned'(-d1_x) : unsigned'(d1_x);
    assign abs_y = d1_y[31] ? unsigned'(-d1_y) : unsigned'(d1_y);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodx_reg  <= NUM2_W'(NUM2_W'(d1_a) * NUM2_W'(abs_x));
            prody_reg  <= NUM2_W'(NUM2_W'(d1_c) * NUM2_W'(abs_y));
            af_reg     <= d1_a;
            cf_reg     <= d1_c;
            zf_reg     <= d1_z;
            cvf_reg    <= d1_cv;
            xneg_f_reg <= d1_x[31];
            yneg_f_reg <= d1_y[31];
            npf_reg    <= d1_np;
            flf_reg    <= d1_fl | d1_sa | d1_sc;
        end
    end

    // second divider: |p| = a*|x|/z, |q| = c*|y|/z
    logic [SIDE2_W-1:0] d2_side_in, d2_side;
    logic [QB-1:0]      d2_p, d2_q, d2_a, d2_c;
    logic               d2_sp, d2_sq;
    logic signed [31:0] d2_cv [0:5];
    logic               d2_xn, d2_yn, d2_np, d2_fl;

    assign d2_side_in = {cvf_reg[0], cvf_reg[1], cvf_reg[2], cvf_reg[3], cvf_reg[4],
                         cvf_reg[5], af_reg, cf_reg, xneg_f_reg, yneg_f_reg,
                         npf_reg, flf_reg};
    assign {d2_cv[0], d2_cv[1], d2_cv[2], d2_cv[3], d2_cv[4], d2_cv[5],
            d2_a, d2_c, d2_xn, d2_yn, d2_np, d2_fl} = d2_side;

    gcp_div_pipe #(
        .NUM_W  (NUM2_W),
        .SIDE_W (SIDE2_W)
    ) u_div_persp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vf_reg),
        .num0      (prodx_reg),
        .num1      (prody_reg),
        .den       (zf_reg),
        .side      (d2_side_in),
        .out_valid (d2_valid),
        .quo0      (d2_p),
        .quo1      (d2_q),
        .sat0      (d2_sp),
        .sat1      (d2_sq),
        .side_out  (d2_side)
    );

    // stage g: J*C partial products; p and q take the opposite sign of x and y
    logic signed [31:0] a_g, c_g, p_g, q_g, pv, qv;
    logic signed [63:0] mp_reg [0:9];
    logic signed [31:0] ag_reg, cg_reg, pg_reg, qg_reg;
    logic               npg_reg, flg_reg;

    assign a_g = {1'b0, d2_a};
    assign c_g = {1'b0, d2_c};
    assign pv  = {1'b0, d2_p};
    assign qv  = {1'b0, d2_q};
    assign p_g = d2_xn ? pv : -pv;
    assign q_g = d2_yn ? qv : -qv;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_reg[0] <= 64'(a_g) * 64'(d2_cv[0]);
            mp_reg[1] <= 64'(p_g) * 64'(d2_cv[2]);
            mp_reg[2] <= 64'(a_g) * 64'(d2_cv[1]);
            mp_reg[3] <= 64'(p_g) * 64'(d2_cv[4]);
            mp_reg[4] <= 64'(a_g) * 64'(d2_cv[2]);
            mp_reg[5] <= 64'(p_g) * 64'(d2_cv[5]);
            mp_reg[6] <= 64'(c_g) * 64'(d2_cv[3]);
            mp_reg[7] <= 64'(q_g) * 64'(d2_cv[4]);
            mp_reg[8] <= 64'(c_g) * 64'(d2_cv[4]);
            mp_reg[9] <= 64'(q_g) * 64'(d2_cv[5]);
            ag_reg    <= a_g;
            cg_reg    <= c_g;
            pg_reg    <= p_g;
            qg_reg    <= q_g;
            npg_reg   <= d2_np;
            flg_reg   <= d2_fl | d2_sp | d2_sq;
        end
    end

    // stage h: M entries m00 m01 m02 m11 m12
    logic signed [64:0] m_sum [0:4];
    sat32_t             m_sat [0:4];
    logic               m_ovf;
    logic signed [31:0] m_reg [0:4];
    logic signed [31:0] ah_reg, ch_reg, ph_reg, qh_reg;
    logic               nph_reg, flh_reg;

    always_comb
    begin
        m_ovf = 1'b0;
        for (int e = 0; e < 5; e++)
        begin
            m_sum[e] = (65'(mp_reg[2*e]) + 65'(mp_reg[2*e+1]) + HALF_F) >>> FRAC_BITS;
            m_sat[e] = sat32(m_sum[e][63:0]);
            m_ovf    = m_ovf | m_sat[e].ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < 5; e++)
            begin
                m_reg[e] <= m_sat[e].val;
            end
            ah_reg  <= ag_reg;
            ch_reg  <= cg_reg;
            ph_reg  <= pg_reg;
            qh_reg  <= qg_reg;
            nph_reg <= npg_reg;
            flh_reg <= flg_reg | m_ovf;
        end
    end

    // stage i: M*J^T partial products
    logic signed [63:0] fp_reg [0:5];
    logic               npi_reg, fli_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fp_reg[0] <= 64'(m_reg[0]) * 64'(ah_reg);
            fp_reg[1] <= 64'(m_reg[2]) * 64'(ph_reg);
            fp_reg[2] <= 64'(m_reg[1]) * 64'(ch_reg);
            fp_reg[3] <= 64'(m_reg[2]) * 64'(qh_reg);
            fp_reg[4] <= 64'(m_reg[3]) * 64'(ch_reg);
            fp_reg[5] <= 64'(m_reg[4]) * 64'(qh_reg);
            npi_reg   <= nph_reg;
            fli_reg   <= flh_reg;
        end
    end

    // stage j: output register
    logic signed [64:0] o_sum [0:2];
    sat48_t             o_sat [0:2];
    logic               o_ovf;
    logic signed [47:0] o_reg [0:2];
    logic [1:0]         status_reg;

    always_comb
    begin
        o_ovf = 1'b0;
        for (int e = 0; e < 3; e++)
        begin
            o_sum[e] = (65'(fp_reg[2*e]) + 65'(fp_reg[2*e+1]) + HALF_F) >>> FRAC_BITS;
            o_sat[e] = sat48(o_sum[e][63:0]);
            o_ovf    = o_ovf | o_sat[e].ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < 3; e++)
            begin
                // depth not positive forces zero
                o_reg[e] <= npi_reg ? 48'sd0 : o_sat[e].val;
            end
            if (npi_reg)
            begin
                status_reg <= ST_NONPOS;
            end
            else if (fli_reg || o_ovf)
            begin
                status_reg <= ST_SAT;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
    end

    // valid bits outside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg           <= 1'b0;
            vb_reg           <= 1'b0;
            vc_reg           <= 1'b0;
            vd_reg           <= 1'b0;
            ve_reg           <= 1'b0;
            vf_reg           <= 1'b0;
            vg_reg           <= 1'b0;
            vh_reg           <= 1'b0;
            vi_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg           <= item_valid;
            vb_reg           <= va_reg;
            vc_reg           <= vb_reg;
            vd_reg           <= vc_reg;
            ve_reg           <= vd_reg;
            vf_reg           <= d1_valid;
            vg_reg           <= d2_valid;
            vh_reg           <= vg_reg;
            vi_reg           <= vh_reg;
            result_valid_reg <= vi_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign screen_cov_xx = o_reg[0];
    assign screen_cov_xy = o_reg[1];
    assign screen_cov_yy = o_reg[2];
    assign status        = status_reg;

    // non-positive depth always comes out as zeros
    a_nonpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_NONPOS |->
            screen_cov_xx == 48'sd0 && screen_cov_xy == 48'sd0 && screen_cov_yy == 48'sd0)
        else $error("non-positive depth with nonzero covariance");

    // input is held back only by a waiting result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled without output back-pressure");

    // a waiting result word is not dropped
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status))
        else $error("result word lost under stall");

endmodule

`default_nettype wire

// ----- rtl/gcp_div_pipe.sv -----
`default_nettype none

// two-lane restoring divider, one quotient bit per stage, shared divisor,
// round to nearest, saturating at 2^QUO_BITS-1
module gcp_div_pipe
    import gcp_pkg::*;
#(
    parameter int NUM_W  = 48,
    parameter int SIDE_W = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [NUM_W-1:0]    num0,
    input  wire logic [NUM_W-1:0]    num1,
    input  wire logic [QUO_BITS-1:0] den,
    input  wire logic [SIDE_W-1:0]   side,
    output logic                     out_valid,
    output logic [QUO_BITS-1:0]      quo0,
    output logic [QUO_BITS-1:0]      quo1,
    output logic                     sat0,
    output logic                     sat1,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int QB = QUO_BITS;

    logic              valid_reg [0:QB];
    logic [QB-1:0]     rem0_reg  [0:QB];
    logic [QB-1:0]     rem1_reg  [0:QB];
    logic [QB-1:0]     low0_reg  [0:QB];
    logic [QB-1:0]     low1_reg  [0:QB];
    logic [QB-1:0]     q0_reg    [0:QB];
    logic [QB-1:0]     q1_reg    [0:QB];
    logic [QB-1:0]     den_reg   [0:QB];
    logic              s0_reg    [0:QB];
    logic              s1_reg    [0:QB];
    logic [SIDE_W-1:0] side_reg  [0:QB];

    logic              out_valid_reg;
    logic [QB-1:0]     quo0_reg, quo1_reg;
    logic              sat0_reg, sat1_reg;
    logic [SIDE_W-1:0] side_out_reg;

    // setup: the quotient overflows when the top part already reaches den
    logic [NUM_W-1:0] hi0, hi1, den_w;
    logic             ov0, ov1;

    assign hi0   = {{QB{1'b0}}, num0[NUM_W-1:QB]};
    assign hi1   = {{QB{1'b0}}, num1[NUM_W-1:QB]};
    assign den_w = {{(NUM_W-QB){1'b0}}, den};
    assign ov0   = hi0 >= den_w;
    assign ov1   = hi1 >= den_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem0_reg[0] <= ov0 ? '0 : hi0[QB-1:0];
            rem1_reg[0] <= ov1 ? '0 : hi1[QB-1:0];
            low0_reg[0] <= num0[QB-1:0];
            low1_reg[0] <= num1[QB-1:0];
            q0_reg[0]   <= '0;
            q1_reg[0]   <= '0;
            den_reg[0]  <= den;
            s0_reg[0]   <= ov0;
            s1_reg[0]   <= ov1;
            side_reg[0] <= side;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [QB:0] t0, t1, d;
        logic        ge0, ge1;

        assign d   = {1'b0, den_reg[k-1]};
        assign t0  = {rem0_reg[k-1], low0_reg[k-1][QB-1]};
        assign t1  = {rem1_reg[k-1], low1_reg[k-1][QB-1]};
        assign ge0 = t0 >= d;
        assign ge1 = t1 >= d;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem0_reg[k] <= ge0 ? QB'(t0 - d) : t0[QB-1:0];
                rem1_reg[k] <= ge1 ? QB'(t1 - d) : t1[QB-1:0];
                low0_reg[k] <= {low0_reg[k-1][QB-2:0], 1'b0};
                low1_reg[k] <= {low1_reg[k-1][QB-2:0], 1'b0};
                q0_reg[k]   <= {q0_reg[k-1][QB-2:0], ge0};
                q1_reg[k]   <= {q1_reg[k-1][QB-2:0], ge1};
                den_reg[k]  <= den_reg[k-1];
                s0_reg[k]   <= s0_reg[k-1];
                s1_reg[k]   <= s1_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // round half up: bump when twice the remainder reaches den
    logic          rnd0, rnd1;
    logic [QB:0]   qi0, qi1;
    logic          so0, so1;

    assign rnd0 = {rem0_reg[QB], 1'b0} >= {1'b0, den_reg[QB]};
    assign rnd1 = {rem1_reg[QB], 1'b0} >= {1'b0, den_reg[QB]};
    assign qi0  = {1'b0, q0_reg[QB]} + (QB+1)'(rnd0);
    assign qi1  = {1'b0, q1_reg[QB]} + (QB+1)'(rnd1);
    assign so0  = s0_reg[QB] | qi0[QB];
    assign so1  = s1_reg[QB] | qi1[QB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo0_reg     <= so0 ? '1 : qi0[QB-1:0];
            quo1_reg     <= so1 ? '1 : qi1[QB-1:0];
            sat0_reg     <= so0;
            sat1_reg     <= so1;
            side_out_reg <= side_reg[QB];
        end
    end

    assign out_valid = out_valid_reg;
    assign quo0      = quo0_reg;
    assign quo1      = quo1_reg;
    assign sat0      = sat0_reg;
    assign sat1      = sat1_reg;
    assign side_out  = side_out_reg;

endmodule

`default_nettype wire
